// ----- sv/mfrf_pkg.sv -----
package mfrf_pkg;

  localparam int MAX_PAYLOAD  = 4096;
  localparam int HEADER_BYTES = 14;
  localparam int ADDR_BYTES   = 6;
  localparam int FCS_BYTES    = 4;

  localparam int ADDR_W    = 48;
  localparam int CFG_W     = 48;
  localparam int LEN_W     = $clog2(MAX_PAYLOAD + 1);
  localparam int HDR_IDX_W = $clog2(HEADER_BYTES);
  localparam int IDX_W     = (LEN_W > HDR_IDX_W) ? LEN_W : HDR_IDX_W;

  localparam logic [31:0]       CRC_POLY   = 32'h04C1_1DB7;
  localparam logic [31:0]       CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0]       CRC_XOROUT = 32'hFFFF_FFFF;
  localparam logic [ADDR_W-1:0] BCAST_ADDR = {ADDR_W{1'b1}};

  localparam logic REG_STATION = 1'b0;
  localparam logic REG_PROMISC = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_DROP    = 2'd1;
  localparam logic [1:0] ST_FCS_ERR = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_FCS     = 2'd2
  } phase_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/mac_frame_receive_filter.sv -----
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------------
// in       | in_valid/in_stall  | rx_byte, phy_mode, phy_symbols
// out      | out_valid/out_stall| out_kind, out_data, out_last, frame_status,
//          |                    | good/drop/fcs_error counts, snap_mode/symbols
// cfg      | cfg_we             | cfg_index, cfg_data
//
// one byte per cycle; each byte is parsed, crc-updated and its result registered
// in the cycle it is taken, so the result appears in the cycle after acceptance
// the single output register sets the rate: input stalls only while it is full
// and stalled
// rst is synchronous: header phase, counters, snapshot and config cleared
module mac_frame_receive_filter
  import mfrf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic [1:0]        phy_mode,
  input  logic [7:0]        phy_symbols,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [7:0]        out_data,
  output logic              out_last,
  output logic [1:0]        frame_status,
  output logic [31:0]       good_count,
  output logic [31:0]       drop_count,
  output logic [31:0]       fcs_error_count,
  output logic [1:0]        snap_mode,
  output logic [7:0]        snap_symbols
);

  logic [ADDR_W-1:0] station_address;
  logic              promiscuous;

  phase_t            phase, phase_next;
  logic [IDX_W-1:0]  byte_index, byte_index_next;
  logic [ADDR_W-1:0] dest_shift, dest_shift_next;
  logic [7:0]        len_hi, len_hi_next;
  logic [LEN_W-1:0]  payload_length, payload_length_next;
  logic [31:0]       crc_reg, crc_reg_next;
  logic [23:0]       fcs_shift, fcs_shift_next;
  logic              accept_flag, accept_flag_next;
  logic [31:0]       good_total, drop_total, fcs_error_total;
  logic [1:0]        held_mode;
  logic [7:0]        held_symbols;

  logic              take;
  logic              res_valid, res_kind, res_last;
  logic [7:0]        res_data;
  logic [1:0]        res_status;
  logic              bump_good, bump_drop, bump_fcs;

  logic [31:0]       crc_step;
  logic              hdr_end, pay_last, fcs_end, fcs_ok;
  logic [15:0]       len_full;
  logic [LEN_W-1:0]  len_clamped;

  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;

  assign crc_step = crc_byte(crc_reg, rx_byte);
  assign hdr_end  = (byte_index == IDX_W'(HEADER_BYTES - 1));
  assign pay_last = (({1'b0, byte_index} + (IDX_W+1)'(1)) ==
                     (IDX_W+1)'(payload_length));
  assign fcs_end  = (byte_index == IDX_W'(FCS_BYTES - 1));
  assign fcs_ok   = ((crc_reg ^ CRC_XOROUT) == {fcs_shift, rx_byte});
  assign len_full = {len_hi, rx_byte};
  assign len_clamped = (len_full > 16'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                     : LEN_W'(len_full);

  // next state
  always_comb begin
    phase_next = phase;
    if (take) begin
      case (phase)
        PH_PAYLOAD: begin
          if (pay_last) begin
            phase_next = PH_FCS;
          end
        end
        PH_FCS: begin
          if (fcs_end) begin
            phase_next = PH_HEADER;
          end
        end
        default: begin
          if (hdr_end) begin
            phase_next = (len_clamped == '0) ? PH_FCS : PH_PAYLOAD;
          end else begin
            phase_next = PH_HEADER;
          end
        end
      endcase
    end
  end

  // datapath and results
  always_comb begin
    byte_index_next     = byte_index;
    dest_shift_next     = dest_shift;
    len_hi_next         = len_hi;
    payload_length_next = payload_length;
    crc_reg_next        = crc_reg;
    fcs_shift_next      = fcs_shift;
    accept_flag_next    = accept_flag;
    res_valid           = 1'b0;
    res_kind            = KIND_PAYLOAD;
    res_data            = 8'h00;
    res_last            = 1'b0;
    res_status          = ST_GOOD;
    bump_good           = 1'b0;
    bump_drop           = 1'b0;
    bump_fcs            = 1'b0;
    if (take) begin
      case (phase)
        PH_PAYLOAD: begin
          crc_reg_next = crc_step;
          byte_index_next = pay_last ? '0 : byte_index + IDX_W'(1);
          res_valid = accept_flag;
          res_data  = rx_byte;
          res_last  = pay_last;
        end
        PH_FCS: begin
          fcs_shift_next = {fcs_shift[15:0], rx_byte};
          if (!fcs_end) begin
            byte_index_next = byte_index + IDX_W'(1);
          end else begin
            byte_index_next = '0;
            crc_reg_next    = CRC_INIT;
            dest_shift_next = '0;
            accept_flag_next = 1'b0;
            res_valid = 1'b1;
            res_kind  = KIND_STATUS;
            if (!accept_flag) begin
              bump_drop  = 1'b1;
              res_status = ST_DROP;
            end else if (!fcs_ok) begin
              bump_fcs   = 1'b1;
              res_status = ST_FCS_ERR;
            end else begin
              bump_good  = 1'b1;
              res_status = ST_GOOD;
            end
          end
        end
        default: begin
          crc_reg_next = crc_step;
          if (byte_index < IDX_W'(ADDR_BYTES)) begin
            dest_shift_next = {dest_shift[ADDR_W-9:0], rx_byte};
          end
          if (byte_index == IDX_W'(HEADER_BYTES - 2)) begin
            len_hi_next = rx_byte;
          end
          if (hdr_end) begin
            payload_length_next = len_clamped;
            accept_flag_next = promiscuous | (dest_shift == BCAST_ADDR) |
                               (dest_shift == station_address);
            byte_index_next = '0;
          end else begin
            byte_index_next = byte_index + IDX_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= '0;
      promiscuous     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STATION: station_address <= cfg_data[ADDR_W-1:0];
        REG_PROMISC: promiscuous     <= cfg_data[0];
        default:     promiscuous     <= promiscuous;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_index      <= '0;
      dest_shift      <= '0;
      crc_reg         <= CRC_INIT;
      accept_flag     <= 1'b0;
      good_total      <= '0;
      drop_total      <= '0;
      fcs_error_total <= '0;
      held_mode       <= '0;
      held_symbols    <= '0;
      out_valid       <= 1'b0;
    end else begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      dest_shift  <= dest_shift_next;
      crc_reg     <= crc_reg_next;
      accept_flag <= accept_flag_next;
      if (bump_good) begin
        good_total   <= good_total + 32'd1;
        held_mode    <= phy_mode;
        held_symbols <= phy_symbols;
      end
      if (bump_drop) begin
        drop_total <= drop_total + 32'd1;
      end
      if (bump_fcs) begin
        fcs_error_total <= fcs_error_total + 32'd1;
      end
      out_valid <= res_valid | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    len_hi         <= len_hi_next;
    payload_length <= payload_length_next;
    fcs_shift      <= fcs_shift_next;
    if (res_valid) begin
      out_kind     <= res_kind;
      out_data     <= res_data;
      out_last     <= res_last;
      frame_status <= res_status;
    end
  end

  assign good_count      = good_total;
  assign drop_count      = drop_total;
  assign fcs_error_count = fcs_error_total;
  assign snap_mode       = held_mode;
  assign snap_symbols    = held_symbols;

endmodule

// ----- sv/mfrf_checker.sv -----
module mfrf_checker
  import mfrf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              cfg_we,
  input logic              cfg_index,
  input logic [CFG_W-1:0]  cfg_data,
  input logic              in_valid,
  input logic              in_stall,
  input logic [7:0]        rx_byte,
  input logic [1:0]        phy_mode,
  input logic [7:0]        phy_symbols,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_kind,
  input logic [7:0]        out_data,
  input logic              out_last,
  input logic [1:0]        frame_status,
  input logic [31:0]       good_count,
  input logic [31:0]       drop_count,
  input logic [31:0]       fcs_error_count,
  input logic [1:0]        snap_mode,
  input logic [7:0]        snap_symbols
);

  // a stalled transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data) && $stable(out_kind)
      && $stable(frame_status) && $stable(out_last))
    else $error("stalled output transaction changed");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_STATUS |-> out_data == 8'h00 && !out_last
      && (frame_status == ST_GOOD || frame_status == ST_DROP
          || frame_status == ST_FCS_ERR))
    else $error("malformed status transaction");

  a_payload_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_PAYLOAD |-> frame_status == ST_GOOD)
    else $error("payload transaction carries a status");

  a_one_counter: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones({good_count != $past(good_count),
      drop_count != $past(drop_count),
      fcs_error_count != $past(fcs_error_count)}) <= 1)
      && (good_count == $past(good_count) || good_count == $past(good_count) + 32'd1))
    else $error("counters moved together or jumped");

endmodule

bind mac_frame_receive_filter mfrf_checker u_mfrf_checker (.*);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
  import mfrf_pkg::*;
();

  localparam int CYCLE_LIMIT = 500_000;
  localparam int PHASE_BYTES = 430;
  localparam int REPORT_CAP  = 200;

  typedef struct {
    logic        kind;
    logic [7:0]  data;
    logic        last;
    logic [1:0]  status;
    logic [31:0] good;
    logic [31:0] drop;
    logic [31:0] fcs_err;
    logic [1:0]  mode;
    logic [7:0]  syms;
  } rx_result_t;

  typedef struct {
    logic [47:0] dest;
    logic [15:0] len_field;
    int          body_len;
    bit          bad_fcs;
    logic [1:0]  mode;
    logic [7:0]  syms;
    logic [1:0]  status;
    logic [31:0] good;
    logic [31:0] drop;
    logic [31:0] fcs_err;
  } frame_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       rx_byte;
  logic [1:0]       phy_mode;
  logic [7:0]       phy_symbols;
  logic             out_valid;
  logic             out_stall;
  logic             out_kind;
  logic [7:0]       out_data;
  logic             out_last;
  logic [1:0]       frame_status;
  logic [31:0]      good_count;
  logic [31:0]      drop_count;
  logic [31:0]      fcs_error_count;
  logic [1:0]       snap_mode;
  logic [7:0]       snap_symbols;

  // frame parser and counter state as the block should hold it
  phase_t      rx_phase;
  logic [15:0] rx_pos;
  logic [47:0] dest_acc;
  logic [15:0] len_hold;
  logic [31:0] crc_acc;
  logic [31:0] fcs_acc;
  logic        frame_taken;
  logic [31:0] good_tally;
  logic [31:0] drop_tally;
  logic [31:0] fcs_err_tally;
  logic [1:0]  mode_hold;
  logic [7:0]  syms_hold;
  logic [47:0] station_cfg;
  logic        promisc_cfg;

  rx_result_t expected_q[$];
  frame_row_t tally_q[$];

  int errors        = 0;
  int checked       = 0;
  int cycles        = 0;
  int bytes_sent    = 0;
  int phase_bytes   = 0;
  int frames_sent   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // dest, length field, payload bytes on the wire, corrupt fcs, phy mode/symbols, then the
  // status and counters read off directly
  frame_row_t directed_frames [5] = '{
    '{48'hFFFF_FFFF_FFFF, 16'd0, 0, 1'b0, 2'd3, 8'hFF, ST_GOOD,    32'd1, 32'd0, 32'd0},
    '{48'h0200_0000_0001, 16'd1, 1, 1'b0, 2'd0, 8'h00, ST_DROP,    32'd1, 32'd1, 32'd0},
    '{48'h0000_0000_0000, 16'd2, 2, 1'b1, 2'd1, 8'hAA, ST_FCS_ERR, 32'd1, 32'd1, 32'd1},
    '{48'h0000_0000_0000, 16'd3, 3, 1'b0, 2'd2, 8'h55, ST_GOOD,    32'd2, 32'd1, 32'd1},
    '{48'h0000_0000_0001, 16'd1, 1, 1'b1, 2'd3, 8'h0F, ST_DROP,    32'd2, 32'd2, 32'd1}
  };

  mac_frame_receive_filter dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {b, 24'h0};
    repeat (8) r = r[31] ? ({r[30:0], 1'b0} ^ CRC_POLY) : {r[30:0], 1'b0};
    return r;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic rx_result_t make_result(input logic kind, input logic [7:0] data,
                                             input logic last, input logic [1:0] status);
    rx_result_t r;
    r.kind    = kind;
    r.data    = data;
    r.last    = last;
    r.status  = status;
    r.good    = good_tally;
    r.drop    = drop_tally;
    r.fcs_err = fcs_err_tally;
    r.mode    = mode_hold;
    r.syms    = syms_hold;
    return r;
  endfunction

  task automatic clear_frame();
    rx_phase    = PH_HEADER;
    rx_pos      = '0;
    dest_acc    = '0;
    len_hold    = '0;
    crc_acc     = CRC_INIT;
    fcs_acc     = '0;
    frame_taken = 1'b0;
  endtask

  task automatic reset_predictor();
    clear_frame();
    good_tally    = '0;
    drop_tally    = '0;
    fcs_err_tally = '0;
    mode_hold     = '0;
    syms_hold     = '0;
    station_cfg   = '0;
    promisc_cfg   = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic [1:0] m, input logic [7:0] s);
    logic        last;
    logic [15:0] len;
    logic [1:0]  st;
    case (rx_phase)
      PH_PAYLOAD: begin
        last    = (32'(rx_pos) + 1 == 32'(len_hold));
        crc_acc = crc_next(crc_acc, b);
        rx_pos  = rx_pos + 16'd1;
        if (last) begin
          rx_phase = PH_FCS;
          rx_pos   = '0;
        end
        if (frame_taken) begin
          expected_q.push_back(make_result(KIND_PAYLOAD, b, last, ST_GOOD));
        end
      end
      PH_FCS: begin
        fcs_acc = {fcs_acc[23:0], b};
        if (rx_pos < 16'd3) begin
          rx_pos = rx_pos + 16'd1;
        end else begin
          if (!frame_taken) begin
            drop_tally = drop_tally + 32'd1;
            st = ST_DROP;
          end else if ((crc_acc ^ CRC_XOROUT) != fcs_acc) begin
            fcs_err_tally = fcs_err_tally + 32'd1;
            st = ST_FCS_ERR;
          end else begin
            good_tally = good_tally + 32'd1;
            mode_hold  = m;
            syms_hold  = s;
            st = ST_GOOD;
          end
          clear_frame();
          expected_q.push_back(make_result(KIND_STATUS, 8'h00, 1'b0, st));
        end
      end
      default: begin
        rx_phase = PH_HEADER;
        crc_acc  = crc_next(crc_acc, b);
        if (rx_pos < 16'(ADDR_BYTES)) dest_acc = {dest_acc[39:0], b};
        if (rx_pos == 16'd12) len_hold = {b, 8'h00};
        if (32'(rx_pos) + 1 >= HEADER_BYTES) begin
          len = len_hold | {8'h00, b};
          if (32'(len) > MAX_PAYLOAD) len = 16'(MAX_PAYLOAD);
          len_hold    = len;
          frame_taken = promisc_cfg || dest_acc == BCAST_ADDR || dest_acc == station_cfg;
          rx_pos      = '0;
          rx_phase    = (len == 16'd0) ? PH_FCS : PH_PAYLOAD;
        end else begin
          rx_pos = rx_pos + 16'd1;
        end
      end
    endcase
  endtask

  // one input transaction, held until taken
  task automatic push_byte(input logic [7:0] b, input logic [1:0] m, input logic [7:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    phy_mode    <= m;
    phy_symbols <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, m, s);
    bytes_sent++;
    phase_bytes++;
  endtask

  task automatic send_frame(input logic [47:0] dest, input logic [15:0] len_field,
                            input int body_len, input bit bad_fcs,
                            input logic [1:0] end_mode, input logic [7:0] end_syms);
    logic [7:0]  wire_q[$];
    logic [31:0] c;
    logic [31:0] fcs;
    for (int i = 0; i < ADDR_BYTES; i++) wire_q.push_back(dest[47 - 8 * i -: 8]);
    for (int i = 0; i < ADDR_BYTES; i++) wire_q.push_back(8'($urandom));
    wire_q.push_back(len_field[15:8]);
    wire_q.push_back(len_field[7:0]);
    for (int i = 0; i < body_len; i++) wire_q.push_back(8'($urandom));
    c = CRC_INIT;
    foreach (wire_q[i]) c = crc_next(c, wire_q[i]);
    fcs = c ^ CRC_XOROUT;
    if (bad_fcs) fcs = fcs ^ (32'h1 << $urandom_range(31));
    for (int i = FCS_BYTES - 1; i >= 0; i--) wire_q.push_back(fcs[8 * i +: 8]);
    foreach (wire_q[i]) begin
      if (i == wire_q.size() - 1) push_byte(wire_q[i], end_mode, end_syms);
      else push_byte(wire_q[i], 2'($urandom), 8'($urandom));
    end
    frames_sent++;
  endtask

  // feed filler until the parser is back at a frame boundary, zero length keeps it short
  task automatic realign();
    while (!(rx_phase == PH_HEADER && rx_pos == 16'd0)) begin
      push_byte((rx_phase == PH_HEADER && rx_pos >= 16'd12) ? 8'h00 : 8'($urandom),
                2'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_frame();
    logic [47:0] dest;
    logic [15:0] len;
    int          body;
    int          pick;
    bit          bad;
    pick = $urandom_range(9);
    if (pick < 3) dest = station_cfg;
    else if (pick < 5) dest = BCAST_ADDR;
    else if (pick == 5) dest = station_cfg ^ (48'h1 << $urandom_range(47));
    else dest = rand48();
    pick = $urandom_range(99);
    if (pick < 8) len = 16'd0;
    else if (pick < 92) len = 16'($urandom_range(1, 40));
    else len = 16'($urandom_range(41, 200));
    body = len;
    bad  = 1'b0;
    pick = $urandom_range(99);
    if (pick < 10) begin
      bad = 1'b1;
    end else if (pick < 18) begin
      if (len >= 16'd3 && $urandom_range(1)) body = len - $urandom_range(1, 3);
      else body = len + $urandom_range(1, 3);
    end
    send_frame(dest, len, body, bad, 2'($urandom), 8'($urandom));
    if (body != int'(len)) realign();
  endtask

  task automatic settle(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_config(input logic [47:0] station, input logic promisc);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STATION;
    cfg_data  <= station;
    @(posedge clk);
    station_cfg = station;
    cfg_index <= REG_PROMISC;
    cfg_data  <= CFG_W'(promisc);
    @(posedge clk);
    promisc_cfg = promisc;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= REPORT_CAP) begin
        $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    rx_result_t want;
    frame_row_t row;
    if (!rst && out_valid && !out_stall) begin
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP) begin
          $display("%0t: result with nothing expected, kind %0h data %0h status %0h",
                   $time, out_kind, out_data, frame_status);
        end
      end else begin
        want = expected_q.pop_front();
        check_field("out_kind", want.kind, out_kind);
        check_field("out_data", want.data, out_data);
        check_field("out_last", want.last, out_last);
        check_field("frame_status", want.status, frame_status);
        check_field("good_count", want.good, good_count);
        check_field("drop_count", want.drop, drop_count);
        check_field("fcs_error_count", want.fcs_err, fcs_error_count);
        check_field("snap_mode", want.mode, snap_mode);
        check_field("snap_symbols", want.syms, snap_symbols);
      end
      if (out_kind == KIND_STATUS && tally_q.size() != 0) begin
        row = tally_q.pop_front();
        check_field("frame_status (table)", row.status, frame_status);
        check_field("good_count (table)", row.good, good_count);
        check_field("drop_count (table)", row.drop, drop_count);
        check_field("fcs_error_count (table)", row.fcs_err, fcs_error_count);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expected_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int pick;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_STATION;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    rx_byte     <= '0;
    phy_mode    <= '0;
    phy_symbols <= '0;
    out_stall   <= 1'b0;
    reset_predictor();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_frames[i]) begin
      tally_q.push_back(directed_frames[i]);
      send_frame(directed_frames[i].dest, directed_frames[i].len_field,
                 directed_frames[i].body_len, directed_frames[i].bad_fcs,
                 directed_frames[i].mode, directed_frames[i].syms);
    end
    settle(4);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          write_config(rand48(), 1'b0);
        end
        1: begin
          send_idle_pct = 88;
          stall_pct     = 0;
          write_config(48'hFFFF_FFFF_FFFF, 1'b1);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 88;
          write_config(48'h0, 1'b0);
        end
        default: begin
          send_idle_pct = 15;
          stall_pct     = 15;
          write_config(rand48(), 1'b0);
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          repeat ($urandom_range(1, 8)) push_byte(8'($urandom), 2'($urandom), 8'($urandom));
          realign();
        end else begin
          random_frame();
        end
        if (pick >= 96) settle(0);
      end
      settle(4);
    end

    $display("%0d bytes in %0d frames sent, %0d results checked over four handshake phases",
             bytes_sent, frames_sent, checked);
    $display("frames ended good %0d, dropped %0d, with fcs error %0d",
             good_tally, drop_tally, fcs_err_tally);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
